/* design/bst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the bounded set table: request codes,
// result status codes, sequencer states and the result word.
// ----------------------------------------------------------------------------
package bst_pkg;

   // default table size
   localparam int DEF_CAPACITY = 16;

   // fixed field widths
   localparam int ELEM_W = 32;
   localparam int OP_W   = 2;
   localparam int OCC_W  = 5;

   // request codes; the unused code behaves as a lookup
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_PRESENT = 2'd2,
      STAT_ABSENT  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_FINISH
   } state_type;

   // one result word from the sequencer to the output stage
   typedef struct packed {
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } res_type;

endpackage

/* design/bst_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_store
// Value memory: one write port and one read port, with registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bst_store #(
   parameter int DEPTH = bst_pkg::DEF_CAPACITY,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [bst_pkg::ELEM_W-1:0]    wr_data,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [bst_pkg::ELEM_W-1:0]    rd_data
);

   logic [bst_pkg::ELEM_W-1:0] store_ff [DEPTH];
   logic [bst_pkg::ELEM_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_ctrl
// Request sequencer: takes one request, scans the stored values one per
// cycle through the memory read port, then appends, moves the last entry
// into a freed slot, or leaves the table alone, and hands out the result.
// ----------------------------------------------------------------------------
module bst_ctrl #(
   parameter int CAPACITY = bst_pkg::DEF_CAPACITY,
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bst_pkg::OP_W-1:0]      req_type,
   input  logic [bst_pkg::ELEM_W-1:0]    req_element,
   // result side
   input  logic                          out_free,
   output logic                          res_load,
   output bst_pkg::res_type              res,
   // memory
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  logic [bst_pkg::ELEM_W-1:0]    mem_rd_data,
   output logic                          mem_we,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output logic [bst_pkg::ELEM_W-1:0]    mem_wr_data
);

   bst_pkg::state_type          state_ff, state_in;
   logic [bst_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bst_pkg::ELEM_W-1:0]  elem_ff, elem_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            scan_idx_ff, scan_idx_in;
   bst_pkg::status_type         status_ff, status_in;

   logic                        hit;
   logic [IDX_W-1:0]            last_idx;
   logic                        scan_last;

   // scan compare against the word read last cycle
   assign hit       = (mem_rd_data == elem_ff);
   assign last_idx  = IDX_W'(count_ff - 1'b1);
   assign scan_last = (scan_idx_ff == last_idx);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bst_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      elem_ff     <= elem_in;
      scan_idx_ff <= scan_idx_in;
      status_ff   <= status_in;
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      elem_in     = elem_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      status_in   = status_ff;
      req_ready   = 1'b0;
      res_load    = 1'b0;
      mem_rd_addr = IDX_W'(scan_idx_ff + 1'b1);
      mem_we      = 1'b0;
      mem_wr_addr = scan_idx_ff;
      mem_wr_data = elem_ff;

      unique case (state_ff)
         bst_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            mem_rd_addr = '0;
            if (req_valid) begin
               op_in       = req_type;
               elem_in     = req_element;
               scan_idx_in = '0;
               if (req_type == bst_pkg::OP_INSERT && count_ff >= CNT_W'(CAPACITY)) begin
                  status_in = bst_pkg::STAT_FULL;
                  state_in  = bst_pkg::S_FINISH;
               end else if (count_ff == '0) begin
                  // empty table: insert goes straight to slot zero
                  if (req_type == bst_pkg::OP_INSERT) begin
                     mem_we      = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = req_element;
                     count_in    = count_ff + 1'b1;
                     status_in   = bst_pkg::STAT_DONE;
                  end else begin
                     status_in   = bst_pkg::STAT_ABSENT;
                  end
                  state_in = bst_pkg::S_FINISH;
               end else begin
                  state_in = bst_pkg::S_SCAN;
               end
            end
         end

         bst_pkg::S_SCAN: begin
            if (hit) begin
               case (op_ff)
                  bst_pkg::OP_INSERT: begin
                     status_in = bst_pkg::STAT_PRESENT;
                     state_in  = bst_pkg::S_FINISH;
                  end
                  bst_pkg::OP_DELETE: begin
                     status_in = bst_pkg::STAT_DONE;
                     count_in  = count_ff - 1'b1;
                     if (scan_last) begin
                        // last slot simply drops off the count
                        state_in = bst_pkg::S_FINISH;
                     end else begin
                        // fetch the last entry to fill the hole
                        mem_rd_addr = last_idx;
                        state_in    = bst_pkg::S_MOVE;
                     end
                  end
                  default: begin
                     status_in = bst_pkg::STAT_DONE;
                     state_in  = bst_pkg::S_FINISH;
                  end
               endcase
            end else if (scan_last) begin
               if (op_ff == bst_pkg::OP_INSERT) begin
                  // append after the last stored entry
                  mem_we      = 1'b1;
                  mem_wr_addr = IDX_W'(count_ff);
                  mem_wr_data = elem_ff;
                  count_in    = count_ff + 1'b1;
                  status_in   = bst_pkg::STAT_DONE;
               end else begin
                  status_in   = bst_pkg::STAT_ABSENT;
               end
               state_in = bst_pkg::S_FINISH;
            end else begin
               scan_idx_in = IDX_W'(scan_idx_ff + 1'b1);
            end
         end

         bst_pkg::S_MOVE: begin
            // last entry moves into the freed slot
            mem_we      = 1'b1;
            mem_wr_addr = scan_idx_ff;
            mem_wr_data = mem_rd_data;
            state_in    = bst_pkg::S_FINISH;
         end

         bst_pkg::S_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = bst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bst_pkg::S_IDLE;
         end
      endcase
   end

   // result word
   assign res.status    = status_ff;
   assign res.occupancy = bst_pkg::OCC_W'(count_ff);

endmodule

/* design/bounded_set_table.sv */
`timescale 1ns / 1ps
// A full-table insert or a request on an empty table goes from acceptance straight to
//   the finish state; otherwise the sequencer scans until it finds the value or passes
//   the last entry, and a delete that moves the last entry also goes through the move state.
//   The scan reads one memory word per cycle. One request is handled at a time; a new
//   request is taken while the previous result waits in the output register.
// Reset clears the count and the handshakes; the value memory is not cleared.
// ----------------------------------------------------------------------------
// bounded_set_table
// Unordered set of up to CAPACITY distinct 32-bit values with insert, delete
// and lookup requests, each answered with a status and the resulting count.
// ----------------------------------------------------------------------------
module bounded_set_table #(
   parameter int CAPACITY = bst_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bst_pkg::OP_W-1:0]      req_type,
   input  logic signed [bst_pkg::ELEM_W-1:0] req_element,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [bst_pkg::OCC_W-1:0]     rsp_occupancy
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                         out_free;
   logic                         res_load;
   bst_pkg::res_type             res;
   logic [IDX_W-1:0]             mem_rd_addr;
   logic [bst_pkg::ELEM_W-1:0]   mem_rd_data;
   logic                         mem_we;
   logic [IDX_W-1:0]             mem_wr_addr;
   logic [bst_pkg::ELEM_W-1:0]   mem_wr_data;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [bst_pkg::OCC_W-1:0]    rsp_occupancy_ff, rsp_occupancy_in;

   // request sequencer
   bst_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_element (req_element),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_we      (mem_we),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // value memory
   bst_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: free when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      if (res_load) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = res.status;
         rsp_occupancy_in = res.occupancy;
      end else if (rsp_ready) begin
         rsp_valid_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // a new word only enters the output register when it is free
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("result loaded over a pending word");

   // memory is never written while the request port is idle with no request offered
   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (!req_ready || req_valid))
      else $error("memory written while idle");

   // accepting a request closes the request port for the next cycle
   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // the loaded count never exceeds the table size
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      res_load |-> (CNT_W'(res.occupancy) <= CNT_W'(CAPACITY)))
      else $error("occupancy beyond capacity");

endmodule
